// ----- rtl/rectangle_outline_fill_rasterizer_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the rectangle rasterizer
// Concurrent checks on the rising edge of clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef RECTANGLE_OUTLINE_FILL_RASTERIZER_ASSERT_SVH
`define RECTANGLE_OUTLINE_FILL_RASTERIZER_ASSERT_SVH

`ifndef SYNTHESIS
`define ROFR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define ROFR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ROFR_ASSERT(lbl, prop, msg)
`define ROFR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/rofr_pkg.sv -----
// ----------------------------------------------------------------------------
// Rectangle rasterizer package
// Shared sizes, command codes, register indexes and a helper function.
// ----------------------------------------------------------------------------
`default_nettype none

package rofr_pkg;

	localparam int MAX_SIDE = 256;
	localparam int SIDE_W   = $clog2(MAX_SIDE);
	localparam int ADDR_W   = 2 * SIDE_W;
	localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
	localparam int PIXEL_W  = 8;
	localparam int REG_W    = 9;
	localparam int COORD_W  = 27;

	typedef logic signed [COORD_W-1:0] coord_t;

	localparam coord_t FX_ONE = COORD_W'(256);

	localparam logic [1:0] KIND_CLEAR = 2'd0;
	localparam logic [1:0] KIND_DRAW  = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	localparam logic [7:0] SHAPE_FILLED  = 8'd82;
	localparam logic [7:0] SHAPE_OUTLINE = 8'd114;

	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_BG     = 2'd2;

	// Index of the last column or row in use for a size register value.
	function automatic logic [SIDE_W-1:0] active_last(input logic [REG_W-1:0] v);
		logic [SIDE_W-1:0] res;
		if (v == '0) begin
			res = '0;
		end else if (v > REG_W'(MAX_SIDE)) begin
			res = SIDE_W'(MAX_SIDE - 1);
		end else begin
			res = SIDE_W'(v - REG_W'(1));
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/rofr_ram.sv -----
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rofr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/rectangle_outline_fill_rasterizer.sv -----
// A read registers the canvas data in the read state, then loads it into the output register
// once the output is free. A clear writes the whole canvas, and a draw scans the active width
// times height, both through the canvas write port at one pixel per cycle. An invalid or ignored
// draw, or an unused command, is accepted without leaving the idle state.
// Reset clears the error flag and the control state and restores the register defaults;
// the canvas memory is not cleared and holds no defined data until the first clear.
// ----------------------------------------------------------------------------
// Rectangle outline and fill rasterizer
// Byte canvas in a synchronous memory, painted by clear and draw requests and
// read one pixel per read request.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rectangle_outline_fill_rasterizer_assert.svh"

module rectangle_outline_fill_rasterizer (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_write,
	input  wire logic [1:0]                          cfg_index,
	input  wire logic [rofr_pkg::REG_W-1:0]          cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [1:0]                          kind,
	input  wire logic [7:0]                          shape_code,
	input  wire logic [7:0]                          paint_byte,
	input  wire logic signed [23:0]                  rect_left,
	input  wire logic signed [23:0]                  rect_top,
	input  wire logic [22:0]                         rect_width,
	input  wire logic [22:0]                         rect_height,
	input  wire logic [7:0]                          read_col,
	input  wire logic [7:0]                          read_row,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [7:0]                               pixel_byte,
	output logic                                     failed
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CLEAR = 2'd1;
	localparam logic [1:0] ST_DRAW  = 2'd2;
	localparam logic [1:0] ST_READ  = 2'd3;

	logic [1:0] state_q;

	logic [rofr_pkg::REG_W-1:0] width_q;
	logic [rofr_pkg::REG_W-1:0] height_q;
	logic [7:0]                 bg_q;
	logic                       error_q;

	logic [rofr_pkg::SIDE_W-1:0] col_q;
	logic [rofr_pkg::SIDE_W-1:0] row_q;
	logic [rofr_pkg::SIDE_W-1:0] last_col_q;
	logic [rofr_pkg::SIDE_W-1:0] last_row_q;
	logic [7:0]                  paint_q;
	logic                        filled_q;

	rofr_pkg::coord_t left_q;
	rofr_pkg::coord_t left_in_q;
	rofr_pkg::coord_t right_q;
	rofr_pkg::coord_t right_in_q;
	rofr_pkg::coord_t top_q;
	rofr_pkg::coord_t top_in_q;
	rofr_pkg::coord_t bottom_q;
	rofr_pkg::coord_t bottom_in_q;

	logic [rofr_pkg::ADDR_W-1:0] rd_addr_q;
	logic                        in_range_q;

	logic                        out_valid_q;
	logic [7:0]                  pixel_q;
	logic                        failed_q;

	logic                        accept;
	logic                        out_free;
	logic                        last_pixel;
	rofr_pkg::coord_t            l_ext;
	rofr_pkg::coord_t            t_ext;
	rofr_pkg::coord_t            r_ext;
	rofr_pkg::coord_t            b_ext;
	rofr_pkg::coord_t            x_pos;
	rofr_pkg::coord_t            y_pos;
	logic                        in_rect;
	logic                        border;
	logic                        draw_valid;

	logic                        ram_we;
	logic [rofr_pkg::ADDR_W-1:0] ram_raddr;
	logic [7:0]                  ram_wdata;
	logic [7:0]                  ram_rdata;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign out_free   = !out_valid_q || out_ready;
	assign last_pixel = (col_q == last_col_q) && (row_q == last_row_q);

	assign l_ext = $signed({{(rofr_pkg::COORD_W-24){rect_left[23]}}, rect_left});
	assign t_ext = $signed({{(rofr_pkg::COORD_W-24){rect_top[23]}}, rect_top});
	assign r_ext = l_ext + $signed({{(rofr_pkg::COORD_W-23){1'b0}}, rect_width});
	assign b_ext = t_ext + $signed({{(rofr_pkg::COORD_W-23){1'b0}}, rect_height});

	assign draw_valid = (rect_width != '0) && (rect_height != '0) &&
		((shape_code == rofr_pkg::SHAPE_FILLED) || (shape_code == rofr_pkg::SHAPE_OUTLINE));

	assign x_pos = $signed({{(rofr_pkg::COORD_W-rofr_pkg::SIDE_W-8){1'b0}}, col_q, 8'd0});
	assign y_pos = $signed({{(rofr_pkg::COORD_W-rofr_pkg::SIDE_W-8){1'b0}}, row_q, 8'd0});

	assign in_rect = (x_pos >= left_q) && (x_pos <= right_q) &&
		(y_pos >= top_q) && (y_pos <= bottom_q);
	assign border = (x_pos < left_in_q) || (x_pos > right_in_q) ||
		(y_pos < top_in_q) || (y_pos > bottom_in_q);

	assign ram_we    = (state_q == ST_CLEAR) ||
		((state_q == ST_DRAW) && in_rect && (border || filled_q));
	assign ram_wdata = paint_q;
	assign ram_raddr = (state_q == ST_IDLE) ? {read_row, read_col} : rd_addr_q;

	rofr_ram #(
		.WIDTH(rofr_pkg::PIXEL_W),
		.DEPTH(rofr_pkg::DEPTH)
	) u_canvas (
		.clk   (clk),
		.we    (ram_we),
		.waddr ({row_q, col_q}),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= rofr_pkg::REG_W'(rofr_pkg::MAX_SIDE);
			height_q <= rofr_pkg::REG_W'(rofr_pkg::MAX_SIDE);
			bg_q     <= 8'd32;
		end else if (cfg_write) begin
			unique case (cfg_index)
				rofr_pkg::CFG_WIDTH:  width_q  <= cfg_data;
				rofr_pkg::CFG_HEIGHT: height_q <= cfg_data;
				rofr_pkg::CFG_BG:     bg_q     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			error_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_READ) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q) inside
				ST_IDLE: begin
					if (accept) begin
						case (kind)
							rofr_pkg::KIND_CLEAR: begin
								error_q <= 1'b0;
								state_q <= ST_CLEAR;
							end
							rofr_pkg::KIND_DRAW: begin
								if (!error_q) begin
									if (draw_valid) begin
										state_q <= ST_DRAW;
									end else begin
										error_q <= 1'b1;
									end
								end
							end
							rofr_pkg::KIND_READ: begin
								state_q <= ST_READ;
							end
							default: ;
						endcase
					end
				end
				ST_CLEAR, ST_DRAW: begin
					if (last_pixel) begin
						state_q <= ST_IDLE;
					end
				end
				ST_READ: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_q       <= '0;
			row_q       <= '0;
			rd_addr_q   <= {read_row, read_col};
			in_range_q  <= (read_col <= rofr_pkg::active_last(width_q)) &&
				(read_row <= rofr_pkg::active_last(height_q));
			filled_q    <= (shape_code == rofr_pkg::SHAPE_FILLED);
			left_q      <= l_ext;
			left_in_q   <= l_ext + rofr_pkg::FX_ONE;
			right_q     <= r_ext;
			right_in_q  <= r_ext - rofr_pkg::FX_ONE;
			top_q       <= t_ext;
			top_in_q    <= t_ext + rofr_pkg::FX_ONE;
			bottom_q    <= b_ext;
			bottom_in_q <= b_ext - rofr_pkg::FX_ONE;
			if (kind == rofr_pkg::KIND_CLEAR) begin
				paint_q    <= bg_q;
				last_col_q <= '1;
				last_row_q <= '1;
			end else begin
				paint_q    <= paint_byte;
				last_col_q <= rofr_pkg::active_last(width_q);
				last_row_q <= rofr_pkg::active_last(height_q);
			end
		end else if ((state_q == ST_CLEAR) || (state_q == ST_DRAW)) begin
			if (col_q == last_col_q) begin
				col_q <= '0;
				row_q <= row_q + rofr_pkg::SIDE_W'(1);
			end else begin
				col_q <= col_q + rofr_pkg::SIDE_W'(1);
			end
		end
		if ((state_q == ST_READ) && out_free) begin
			pixel_q  <= in_range_q ? ram_rdata : 8'd0;
			failed_q <= error_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_byte = pixel_q;
	assign failed     = failed_q;

	`ROFR_ASSERT(a_write_only_when_busy, ram_we |-> ((state_q == ST_CLEAR) || (state_q == ST_DRAW)), "canvas written outside a clear or draw")
	`ROFR_ASSERT(a_read_delivers, ((state_q == ST_READ) && !out_valid_q) |=> out_valid_q, "read request not delivered")
	`ROFR_ASSERT(a_clear_resets_error, (state_q == ST_CLEAR) |-> !error_q, "error flag set during a clear")
	`ROFR_ASSERT_ALWAYS(a_reset_idle, $rose(arst_n) |-> ((state_q == ST_IDLE) && !out_valid_q), "control state not cleared by reset")

endmodule

`default_nettype wire
